FILE: hw/rtl/apfm_pkg.sv
// Package: shared types and constants for the aging page frame manager.
`timescale 1ns / 1ps
package apfm_pkg;
  localparam int FRAMES = 64;
  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = IDX_W + 1;
  localparam int AGE_BITS = 16;
  localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  localparam logic [2:0] CMD_FREE = 3'd0;
  localparam logic [2:0] CMD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_MAP = 3'd2;
  localparam logic [2:0] CMD_ACCESS = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  // flag bits
  localparam int FL_USER = 0;
  localparam int FL_VALID = 1;
  localparam int FL_COW = 2;
  localparam int FL_ACC = 3;
  localparam int FL_SWAP = 4;

  typedef struct packed {
    logic [2:0] command;
    logic [5:0] frame_index;
    logic attach;
    logic user_page;
    logic valid_page;
    logic cow_page;
    logic preset_age;
  } req_t;

  typedef struct packed {
    logic [5:0] granted_frame;
    logic ok;
    logic evicted;
    logic [6:0] active_count;
    logic thrashing;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, reset scan index
    logic step;      // process entry at scan index
    logic finish;    // apply result and build response
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic single;    // command needs no scan
    logic last;      // scan index at last entry
    logic hit;       // free-frame search found a frame
  } sts_t;
endpackage

FILE: hw/rtl/apfm_if.sv
// Interfaces: request, response and configuration channels.
`timescale 1ns / 1ps
interface apfm_req_if;
  import apfm_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface apfm_rsp_if;
  import apfm_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface apfm_cfg_if;
  logic valid;
  logic ready;
  logic [6:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/aging_page_frame_manager.sv
// Top level: aging page frame manager.
// One command at a time. Free, map, access and unknown commands need no scan;
// alloc with a free frame scans up to the lowest free frame; victim alloc and
// tick scan all 64 frame entries, one per cycle, through a registered table
// read. The result is held in an output register; a new command is accepted
// only while the held result is not stalled.
`timescale 1ns / 1ps
module aging_page_frame_manager (
  input logic     clk,
  input logic     rst,
  apfm_req_if.sink   req,
  apfm_rsp_if.source rsp,
  apfm_cfg_if.sink   cfg
);
  import apfm_pkg::*;
  ctl_t ctl;
  sts_t sts;

  assign cfg.ready = 1'b1;

  apfm_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts(sts), .ctl(ctl)
  );

  apfm_dp u_dp (
    .clk(clk), .rst(rst), .req(req.data), .ctl(ctl), .sts(sts),
    .cfg_we(cfg.valid), .cfg_data(cfg.data), .rsp(rsp.data)
  );
endmodule

FILE: hw/rtl/apfm_ctrl.sv
// Controller: sequences each command through load, scan (with a flush after a full scan) and finish.
`timescale 1ns / 1ps
module apfm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  apfm_pkg::sts_t  sts,
  output apfm_pkg::ctl_t  ctl
);
  import apfm_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state, state_next;
  logic out_valid_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    ctl = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.step = !sts.single;
        if (sts.single || sts.hit) state_next = S_DONE;
        else if (sts.last) state_next = S_FLUSH;
      end
      // last table read still in the pipeline
      S_FLUSH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.finish = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

FILE: hw/rtl/apfm_dp.sv
// Datapath: frame table, scan pointer, victim search, aging and response.
`timescale 1ns / 1ps
module apfm_dp (
  input  logic            clk,
  input  logic            rst,
  input  apfm_pkg::req_t  req,
  input  apfm_pkg::ctl_t  ctl,
  output apfm_pkg::sts_t  sts,
  input  logic            cfg_we,
  input  logic [6:0]      cfg_data,
  output apfm_pkg::rsp_t  rsp
);
  import apfm_pkg::*;

  logic [FRAMES-1:0] frame_free;
  logic [FRAMES-1:0] frame_mapped;
  logic [FRAMES-1:0] age_set;   // entry holds a written age, else reads zero
  logic [4:0] frame_flags [FRAMES];
  logic [AGE_BITS-1:0] frame_age [FRAMES];
  logic [CNT_W-1:0] free_count;
  logic [6:0] thrash_limit;

  req_t r;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] ip;
  logic [AGE_BITS-1:0] min_age;
  logic have_victim, have_reserve, found;
  logic [IDX_W-1:0] victim, reserve, hit_idx;
  logic [CNT_W-1:0] count;

  logic [IDX_W-1:0] ri;
  logic ri_ok, cur_res, cur_elig, tick_wb;

  // registered table read, one stage behind the scan pointer
  logic [IDX_W-1:0] rd_addr, ip_q;
  logic pv;
  logic [4:0] flags_q;
  logic [AGE_BITS-1:0] age_q, cur_age;

  logic fl_we, ag_we;
  logic [IDX_W-1:0] fl_wa, ag_wa;
  logic [4:0] fl_wd;
  logic [AGE_BITS-1:0] ag_wd;
  rsp_t rsp_next;

  assign ip = idx[IDX_W-1:0];
  assign ri = r.frame_index[IDX_W-1:0];
  assign ri_ok = {1'b0, r.frame_index} < 7'(FRAMES);
  assign rd_addr = ctl.step ? ip : ri;
  assign cur_age = age_set[ip_q] ? age_q : '0;
  assign cur_res = !frame_free[ip_q] && frame_mapped[ip_q] && flags_q[FL_USER] &&
                   !flags_q[FL_SWAP];
  assign cur_elig = cur_res && flags_q[FL_VALID] && !flags_q[FL_COW];
  assign tick_wb = pv && (r.command == CMD_TICK) && cur_res;

  assign sts.single = !(r.command == CMD_TICK ||
                        (r.command == CMD_ALLOC && free_count == '0)) &&
                      !(r.command == CMD_ALLOC);
  assign sts.last = (ip == IDX_W'(FRAMES - 1));
  assign sts.hit = (r.command == CMD_ALLOC) && (free_count != '0) && frame_free[ip];

  logic have_v_f;
  logic [IDX_W-1:0] vic_f;
  assign have_v_f = have_victim || have_reserve;
  assign vic_f = have_victim ? victim : reserve;

  logic [CNT_W:0] cnt_w;
  assign cnt_w = {1'b0, count};

  // table write port
  always_comb begin
    fl_we = 1'b0;
    fl_wa = ri;
    fl_wd = '0;
    ag_we = 1'b0;
    ag_wa = ri;
    ag_wd = AGE_TOP;
    if (tick_wb) begin
      fl_we = 1'b1;
      fl_wa = ip_q;
      fl_wd = flags_q;
      fl_wd[FL_ACC] = 1'b0;
      ag_we = 1'b1;
      ag_wa = ip_q;
      ag_wd = {flags_q[FL_ACC], cur_age[AGE_BITS-1:1]};
    end else if (ctl.finish) begin
      case (r.command)
        CMD_FREE: begin
          fl_we = ri_ok;
        end
        CMD_ALLOC: begin
          if (!found && free_count == '0 && have_v_f) begin
            fl_we = 1'b1;
            fl_wa = vic_f;
            ag_we = 1'b1;
            ag_wa = vic_f;
          end
        end
        CMD_MAP: begin
          if (ri_ok) begin
            fl_we = 1'b1;
            fl_wd = {2'b00, r.cow_page, r.valid_page, r.user_page};
            ag_we = r.preset_age;
          end
        end
        CMD_ACCESS: begin
          if (ri_ok && frame_mapped[ri]) begin
            fl_we = 1'b1;
            fl_wd = flags_q;
            fl_wd[FL_ACC] = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp_next = '0;
    case (r.command)
      CMD_ALLOC: begin
        if (found) begin
          rsp_next.granted_frame = 6'(hit_idx);
          rsp_next.ok = 1'b1;
        end else if (free_count == '0 && have_v_f) begin
          rsp_next.granted_frame = 6'(vic_f);
          rsp_next.ok = 1'b1;
          rsp_next.evicted = 1'b1;
        end
      end
      CMD_TICK: begin
        rsp_next.active_count = (cnt_w > 8'd127) ? 7'd127 : 7'(count);
        rsp_next.thrashing = cnt_w > {1'b0, thrash_limit};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fl_we) frame_flags[fl_wa] <= fl_wd;
    if (ag_we) frame_age[ag_wa] <= ag_wd;
    flags_q <= frame_flags[rd_addr];
    age_q <= frame_age[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_free <= '0;
      frame_mapped <= '0;
      age_set <= '0;
      free_count <= '0;
      thrash_limit <= 7'd64;
      pv <= 1'b0;
    end else begin
      if (cfg_we) thrash_limit <= cfg_data;
      pv <= ctl.step;
      if (ag_we) age_set[ag_wa] <= 1'b1;
      if (ctl.load) begin
        r <= req;
        idx <= '0;
        min_age <= AGE_MAX;
        have_victim <= 1'b0;
        have_reserve <= 1'b0;
        found <= 1'b0;
        count <= '0;
      end
      if (ctl.step) begin
        idx <= idx + 1'b1;
        ip_q <= ip;
        if (r.command != CMD_TICK && free_count != '0 && frame_free[ip]) begin
          found <= 1'b1;
          hit_idx <= ip;
        end
      end
      if (pv) begin
        if (r.command == CMD_TICK) begin
          if (cur_res && (flags_q[FL_ACC] || cur_age != '0)) count <= count + 1'b1;
        end else if (free_count == '0 && cur_elig) begin
          reserve <= ip_q;
          have_reserve <= 1'b1;
          if (cur_age < min_age) begin
            min_age <= cur_age;
            victim <= ip_q;
            have_victim <= 1'b1;
          end
        end
      end
      if (ctl.finish) begin
        rsp <= rsp_next;
        case (r.command)
          CMD_FREE: begin
            if (ri_ok) begin
              if (!frame_free[ri]) free_count <= free_count + 1'b1;
              frame_free[ri] <= 1'b1;
              frame_mapped[ri] <= 1'b0;
              age_set[ri] <= 1'b0;
            end
          end
          CMD_ALLOC: begin
            if (found) begin
              frame_free[hit_idx] <= 1'b0;
              free_count <= free_count - 1'b1;
            end else if (free_count == '0 && have_v_f) begin
              frame_mapped[vic_f] <= 1'b0;
            end
          end
          CMD_MAP: begin
            if (ri_ok) frame_mapped[ri] <= r.attach;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: hw/rtl/apfm_checker.sv
// Checker: port-level properties of the frame manager, with bind.
`timescale 1ns / 1ps
module apfm_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input apfm_pkg::rsp_t rsp_data
);
  import apfm_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second transfer accepted while busy");
  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.evicted |-> rsp_data.ok)
    else $error("evicted without ok");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.ok |-> rsp_data.active_count == '0 && !rsp_data.thrashing)
    else $error("alloc result with tick fields");
endmodule

bind aging_page_frame_manager apfm_checker u_chk (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
